FILE: hw/rtl/i2c_humidity_temp_sensor_model_top_macros.svh
// assertion macros for the sensor model checker
`ifndef I2C_HUMIDITY_TEMP_SENSOR_MODEL_TOP_MACROS_SVH
`define I2C_HUMIDITY_TEMP_SENSOR_MODEL_TOP_MACROS_SVH

// same-cycle implication, disabled while en is low
`define IHTS_ASSERT_NOW(label, clk, en, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(en)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while en is low
`define IHTS_ASSERT_NEXT(label, clk, en, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ihts_pkg.sv
// shared types and constants of the humidity and temperature sensor model
`timescale 1ns / 1ps

package ihts_pkg;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_TEMP,
        PEND_HUMI,
        PEND_UREG
    } t_pend;

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_READ,
        MODE_WRITE_READ,
        MODE_NONE
    } t_mode;

    localparam logic [7:0] CMD_MEAS_T     = 8'hF3;
    localparam logic [7:0] CMD_MEAS_RH    = 8'hF5;
    localparam logic [7:0] CMD_READ_UREG  = 8'hE7;
    localparam logic [7:0] CMD_WRITE_UREG = 8'hE6;
    localparam logic [7:0] CMD_SOFT_RESET = 8'hFE;
    localparam logic [7:0] UREG_DEFAULT   = 8'h02;

    localparam logic [0:0] CFG_TEMPERATURE = 1'b0;
    localparam logic [0:0] CFG_HUMIDITY    = 1'b1;

    localparam logic signed [14:0] TEMP_RESET = 15'sd2500;
    localparam logic signed [14:0] HUMI_RESET = 15'sd5000;
    localparam logic signed [14:0] TEMP_LO    = -15'sd4685;
    localparam logic signed [14:0] TEMP_HI    = 15'sd12887;
    localparam logic signed [14:0] HUMI_LO    = -15'sd600;
    localparam logic signed [14:0] HUMI_HI    = 15'sd11900;

    localparam logic [14:0] TEMP_SPAN = 15'd17572;
    localparam logic [14:0] HUMI_SPAN = 15'd12500;
    localparam logic [30:0] TEMP_HALF = 31'd8786;
    localparam logic [30:0] HUMI_HALF = 31'd6250;

    // reciprocal of the span scaled by 2^RECIP_SHIFT, rounded down
    localparam int          RECIP_SHIFT = 45;
    localparam logic [31:0] TEMP_RECIP  = 32'((64'd1 << RECIP_SHIFT) / 64'd17572);
    localparam logic [31:0] HUMI_RECIP  = 32'((64'd1 << RECIP_SHIFT) / 64'd12500);

    localparam logic [15:0] CODE_MAX = 16'hFFFF;

    // job queue between front and back
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;

    // one transaction word, last field in the lowest bits
    typedef struct packed {
        logic [6:0] read_length;
        logic [7:0] data_byte;
        logic [7:0] command_byte;
        logic [7:0] write_length;
        logic [6:0] address;
        logic [1:0] mode;
    } t_txn;

    // read job as classified by the front
    typedef struct packed {
        t_pend      sel;
        logic       ack;
        logic [7:0] ureg;
    } t_job;

    // resolved read bytes handed to the back
    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] lo;
        logic       ack;
    } t_res;

endpackage

FILE: hw/rtl/ihts_front.sv
// front: accepts transactions, runs sensor commands, issues read jobs
`timescale 1ns / 1ps

module ihts_front #(
    parameter int MAX_READ       = 64,
    parameter int SENSOR_ADDRESS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ihts_pkg::t_txn                      i_txn,
    input  logic                                i_pop,
    output logic                                o_valid,
    output ihts_pkg::t_job                      o_job,
    output logic [$clog2(MAX_READ + 1) - 1:0]   o_cnt
);
    import ihts_pkg::*;

    localparam int CW = $clog2(MAX_READ + 1);
    localparam int UW = $clog2(Q_DEPTH + 1);

    logic [7:0]    r_ureg, n_ureg;
    t_pend         r_pend, n_pend;
    logic [UW-1:0] r_used, n_used;
    logic          r_valid;
    t_job          r_job;
    logic [CW-1:0] r_cnt;

    t_mode         mode;
    logic          accept, ack, wr_hit, rd_go;
    t_pend         pend_w;
    logic [7:0]    ureg_w;
    logic [CW-1:0] cnt;

    // credits cover the pipeline and the queue, so a push never finds it full
    assign o_ready = (r_used < UW'(Q_DEPTH));

    always_comb begin
        mode   = t_mode'(i_txn.mode);
        accept = i_valid && o_ready;
        ack    = (i_txn.address == 7'(SENSOR_ADDRESS));
        wr_hit = ((mode == MODE_WRITE) || (mode == MODE_WRITE_READ)) && ack
                 && (i_txn.write_length != 8'd0);
        rd_go  = ((mode == MODE_READ) || (mode == MODE_WRITE_READ))
                 && (i_txn.read_length != 7'd0);

        pend_w = r_pend;
        ureg_w = r_ureg;
        if (wr_hit) begin
            case (i_txn.command_byte)
                CMD_MEAS_T:     pend_w = PEND_TEMP;
                CMD_MEAS_RH:    pend_w = PEND_HUMI;
                CMD_READ_UREG:  pend_w = PEND_UREG;
                CMD_WRITE_UREG: begin
                    if (i_txn.write_length >= 8'd2) begin
                        ureg_w = i_txn.data_byte;
                    end
                    pend_w = PEND_NONE;
                end
                CMD_SOFT_RESET: begin
                    ureg_w = UREG_DEFAULT;
                    pend_w = PEND_NONE;
                end
                default:        pend_w = PEND_NONE;
            endcase
        end

        if (int'(i_txn.read_length) > MAX_READ) begin
            cnt = CW'(MAX_READ);
        end else begin
            cnt = CW'(i_txn.read_length);
        end

        n_pend = r_pend;
        n_ureg = r_ureg;
        if (accept) begin
            n_ureg = ureg_w;
            n_pend = (rd_go && ack) ? PEND_NONE : pend_w;
        end
        n_used = r_used + UW'(accept && rd_go) - UW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_ureg  <= UREG_DEFAULT;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_ureg  <= n_ureg;
            r_used  <= n_used;
            r_valid <= accept && rd_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.sel  <= ack ? pend_w : PEND_NONE;
            r_job.ack  <= ack;
            r_job.ureg <= ureg_w;
            r_cnt      <= cnt;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
    assign o_cnt   = r_cnt;

endmodule

FILE: hw/rtl/ihts_code.sv
// raw code unit: holds the simulated readings and scales them to 16-bit codes
`timescale 1ns / 1ps

module ihts_code #(
    parameter int MAX_READ = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [14:0]                         i_cfg_wdata,
    input  logic                                i_valid,
    input  ihts_pkg::t_job                      i_job,
    input  logic [$clog2(MAX_READ + 1) - 1:0]   i_cnt,
    output logic                                o_valid,
    output ihts_pkg::t_res                      o_res,
    output logic [$clog2(MAX_READ + 1) - 1:0]   o_cnt
);
    import ihts_pkg::*;

    localparam int CW = $clog2(MAX_READ + 1);

    logic signed [14:0] r_temp, r_humi;

    // clamp and offset stage
    logic          r_v2;
    t_job          r_job2;
    logic [CW-1:0] r_cnt2;
    logic [30:0]   r_x2;
    // reciprocal multiply stage
    logic          r_v3;
    t_job          r_job3;
    logic [CW-1:0] r_cnt3;
    logic [30:0]   r_x3;
    logic [16:0]   r_qest3;

    logic signed [14:0] t_clamp, h_clamp;
    logic [14:0]        t_off, h_off;
    logic [30:0]        x;
    logic [62:0]        prod;
    logic [14:0]        span;
    logic [31:0]        back_prod, rem;
    logic [16:0]        q;
    logic [15:0]        code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= TEMP_RESET;
            r_humi <= HUMI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMPERATURE: r_temp <= i_cfg_wdata;
                CFG_HUMIDITY:    r_humi <= i_cfg_wdata;
                default:         r_temp <= r_temp;
            endcase
        end
    end

    always_comb begin
        t_clamp = (r_temp < TEMP_LO) ? TEMP_LO : ((r_temp > TEMP_HI) ? TEMP_HI : r_temp);
        h_clamp = (r_humi < HUMI_LO) ? HUMI_LO : ((r_humi > HUMI_HI) ? HUMI_HI : r_humi);
        // the offset fits 15 unsigned bits even where the signed sum wraps
        t_off   = 15'(t_clamp - TEMP_LO);
        h_off   = 15'(h_clamp - HUMI_LO);
        if (i_job.sel == PEND_HUMI) begin
            x = {h_off, 16'h0000} + HUMI_HALF;
        end else begin
            x = {t_off, 16'h0000} + TEMP_HALF;
        end
    end

    always_comb begin
        if (r_job2.sel == PEND_HUMI) begin
            prod = 63'(r_x2) * 63'(HUMI_RECIP);
        end else begin
            prod = 63'(r_x2) * 63'(TEMP_RECIP);
        end
    end

    // estimate is exact or one short; one compare fixes it
    always_comb begin
        span      = (r_job3.sel == PEND_HUMI) ? HUMI_SPAN : TEMP_SPAN;
        back_prod = 32'(r_qest3 * 32'(span));
        rem       = 32'(r_x3) - back_prod;
        q         = (rem >= 32'(span)) ? (r_qest3 + 17'd1) : r_qest3;
        code      = (q > 17'(CODE_MAX)) ? CODE_MAX : q[15:0];

        o_res.ack = r_job3.ack;
        case (r_job3.sel)
            PEND_TEMP, PEND_HUMI: begin
                o_res.hi = code[15:8];
                o_res.lo = code[7:0];
            end
            PEND_UREG: begin
                o_res.hi = r_job3.ureg;
                o_res.lo = 8'h00;
            end
            default: begin
                o_res.hi = 8'h00;
                o_res.lo = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job2  <= i_job;
        r_cnt2  <= i_cnt;
        r_x2    <= x;
        r_job3  <= r_job2;
        r_cnt3  <= r_cnt2;
        r_x3    <= r_x2;
        r_qest3 <= 17'(prod >> RECIP_SHIFT);
    end

    assign o_valid = r_v3;
    assign o_cnt   = r_cnt3;

endmodule

FILE: hw/rtl/ihts_queue.sv
// short job queue between the raw code unit and the byte emitter
`timescale 1ns / 1ps

module ihts_queue #(
    parameter int DW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    import ihts_pkg::*;

    logic [DW-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_fill <= r_fill + (Q_AW + 1)'(i_push) - (Q_AW + 1)'(i_pop);
        end
    end

    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd];

endmodule

FILE: hw/rtl/ihts_back.sv
// back: walks one read job out as a byte stream through an output register
`timescale 1ns / 1ps

module ihts_back #(
    parameter int MAX_READ = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  ihts_pkg::t_res                      i_res,
    input  logic [$clog2(MAX_READ + 1) - 1:0]   i_cnt,
    output logic                                o_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser
);
    import ihts_pkg::*;

    localparam int CW = $clog2(MAX_READ + 1);

    logic [CW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last, r_out_ack;

    logic          load, is_last;
    logic [7:0]    byte_sel;

    always_comb begin
        load    = i_valid && (!r_out_valid || m_axis_tready);
        is_last = (r_idx == (i_cnt - CW'(1)));
        if (r_idx == '0) begin
            byte_sel = i_res.hi;
        end else if (r_idx == CW'(1)) begin
            byte_sel = i_res.lo;
        end else begin
            byte_sel = 8'h00;
        end
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? '0 : (r_idx + CW'(1));
        end
        o_pop = load && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= byte_sel;
            r_out_last <= is_last;
            r_out_ack  <= i_res.ack;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ack;

endmodule

FILE: hw/rtl/i2c_humidity_temp_sensor_model_top.sv
// a job passes the front job register, code stages and queue into the output register
// throughput: one transaction word per cycle while fewer than 8 read jobs are outstanding
// output: one read byte per cycle while the sink is ready, one read job at a time
// the raw code path is a reciprocal multiply pipeline in front of the queue
// reset (synchronous, active low): no pending command, user register 0x02,
// readings 25.00 C and 50.00 %, queue and output register empty
`timescale 1ns / 1ps

module i2c_humidity_temp_sensor_model_top #(
    parameter int MAX_READ       = 64,
    parameter int SENSOR_ADDRESS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes: index 0 temperature, index 1 humidity
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [14:0] i_cfg_wdata,
    // transaction words in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], address[8:2], write_length[16:9], command_byte[24:17],
    // data_byte[32:25], read_length[39:33]
    input  logic [39:0] s_axis_tdata,
    // read bytes out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    // last byte of a read
    output logic        m_axis_tlast,
    // acknowledged[0]
    output logic        m_axis_tuser
);
    import ihts_pkg::*;

    localparam int CW = $clog2(MAX_READ + 1);
    localparam int DW = $bits(t_res) + CW;

    t_txn          txn;
    logic          job_valid, res_valid, q_valid, pop;
    t_job          job;
    t_res          res, q_res;
    logic [CW-1:0] job_cnt, res_cnt, q_cnt;
    logic [DW-1:0] q_data;

    assign txn = t_txn'(s_axis_tdata);

    // command handling, pending state, credit count for the queue
    ihts_front #(
        .MAX_READ       (MAX_READ),
        .SENSOR_ADDRESS (SENSOR_ADDRESS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_txn   (txn),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (job),
        .o_cnt   (job_cnt)
    );

    // readings registers and raw code scaling
    ihts_code #(
        .MAX_READ (MAX_READ)
    ) u_code (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (job_valid),
        .i_job       (job),
        .i_cnt       (job_cnt),
        .o_valid     (res_valid),
        .o_res       (res),
        .o_cnt       (res_cnt)
    );

    // resolved jobs wait here so front and back stall independently
    ihts_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  ({res, res_cnt}),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_res = t_res'(q_data[DW-1:CW]);
    assign q_cnt = q_data[CW-1:0];

    // byte emitter with the output register
    ihts_back #(
        .MAX_READ (MAX_READ)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_res         (q_res),
        .i_cnt         (q_cnt),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/ihts_checker.sv
// port-level checker for the sensor model, bound to the top level
`timescale 1ns / 1ps
`include "i2c_humidity_temp_sensor_model_top_macros.svh"

module ihts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic       i_m_tlast,
    input logic       i_m_tuser
);
    // byte position within the current read, saturating at two
    logic [1:0] r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else if (i_m_tvalid && i_m_tready) begin
            if (i_m_tlast) begin
                r_pos <= 2'd0;
            end else if (r_pos != 2'd2) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    `IHTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast) && $stable(i_m_tuser), "stalled read word changed")
    `IHTS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_m_tvalid, "read word valid right after reset")
    `IHTS_ASSERT_NOW(a_nack_zero, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser, i_m_tdata == 8'h00, "unacknowledged read returned data")
    `IHTS_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, i_m_tvalid && (r_pos == 2'd2), i_m_tdata == 8'h00, "padding byte not zero")

endmodule

bind i2c_humidity_temp_sensor_model_top ihts_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_m_tuser  (m_axis_tuser)
);

FILE: bench/testbench.sv
// self-checking stream testbench for the humidity and temperature sensor model
`timescale 1ns / 1ps

module testbench;
    import ihts_pkg::*;

    localparam int SENSOR_ADDR  = 64;
    localparam int MAX_BYTES    = 64;
    // settle time after the stream is empty; leave margin over the pipeline registers
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PHASES  = 7;
    localparam int RAND_PER_PHASE = 54;
    localparam int BURST_WORDS  = 40;

    // one expected read byte with its side-band flags
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ack;
    } sensor_byte_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [0:0]  i_cfg_index   = CFG_TEMPERATURE;
    logic [14:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    // words waiting for the driver, bytes waiting for the monitor
    t_txn         pending_txns[$];
    sensor_byte_t expected_bytes[$];

    // own copy of the sensor state and readings
    logic signed [14:0] model_temp = TEMP_RESET;
    logic signed [14:0] model_humi = HUMI_RESET;
    logic [7:0]         model_ureg = UREG_DEFAULT;
    t_pend              model_pend = PEND_NONE;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int words_taken   = 0;
    int bytes_checked = 0;
    int settings_used = 0;
    int fail_count    = 0;

    i2c_humidity_temp_sensor_model_top #(
        .MAX_READ       (MAX_BYTES),
        .SENSOR_ADDRESS (SENSOR_ADDR)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(64'd100_000_000);
        $display("i2c_humidity_temp_sensor_model_top test failed");
        $finish;
    end

    // clamp, shift to zero, scale to 16 bits with round half up, saturate
    function automatic logic [15:0] raw_code(int value, int lo, int hi, int span);
        int     clamped;
        longint scaled;
        clamped = (value < lo) ? lo : ((value > hi) ? hi : value);
        scaled  = (longint'(clamped - lo) * 65536 + span / 2) / span;
        return (scaled > 65535) ? 16'hFFFF : scaled[15:0];
    endfunction

    // apply one accepted transaction word and queue the bytes it reads back
    function automatic void predict_transaction(t_txn txn);
        t_mode        mode;
        logic         ack;
        int           count;
        logic [7:0]   first_byte;
        logic [7:0]   second_byte;
        logic [15:0]  code;
        sensor_byte_t item;
        mode = t_mode'(txn.mode);
        if (mode == MODE_NONE) return;
        ack = (txn.address == SENSOR_ADDR);
        // write phase only lands on the sensor address with a nonzero length
        if (mode != MODE_READ && ack && txn.write_length != 0) begin
            case (txn.command_byte)
                CMD_MEAS_T:    model_pend = PEND_TEMP;
                CMD_MEAS_RH:   model_pend = PEND_HUMI;
                CMD_READ_UREG: model_pend = PEND_UREG;
                CMD_WRITE_UREG: begin
                    if (txn.write_length >= 2) model_ureg = txn.data_byte;
                    model_pend = PEND_NONE;
                end
                CMD_SOFT_RESET: begin
                    model_ureg = UREG_DEFAULT;
                    model_pend = PEND_NONE;
                end
                default:       model_pend = PEND_NONE;
            endcase
        end
        // zero read length keeps the pending command
        if (mode == MODE_WRITE || txn.read_length == 0) return;
        count = (txn.read_length > MAX_BYTES) ? MAX_BYTES : int'(txn.read_length);
        first_byte  = '0;
        second_byte = '0;
        if (ack) begin
            case (model_pend)
                PEND_TEMP: begin
                    code = raw_code(model_temp, TEMP_LO, TEMP_HI, TEMP_SPAN);
                    {first_byte, second_byte} = code;
                end
                PEND_HUMI: begin
                    code = raw_code(model_humi, HUMI_LO, HUMI_HI, HUMI_SPAN);
                    {first_byte, second_byte} = code;
                end
                PEND_UREG: first_byte = model_ureg;
                default: ;
            endcase
            model_pend = PEND_NONE;
        end
        for (int i = 0; i < count; i++) begin
            item.data = (i == 0) ? first_byte : ((i == 1) ? second_byte : 8'h00);
            item.last = (i == count - 1);
            item.ack  = ack;
            expected_bytes.push_back(item);
        end
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(60, 15);
        return $urandom_range(3, 1);
    endfunction

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", what);
    endfunction

    // driver: one word on the slave side, next one after a random gap
    always @(posedge i_clk) begin
        bit busy;
        busy = s_axis_tvalid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                // prediction happens at acceptance, in stream order
                predict_transaction(t_txn'(s_axis_tdata));
                words_taken++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (pending_txns.size() > 0) begin
                    s_axis_tdata  <= pending_txns.pop_front();
                    s_axis_tvalid <= 1'b1;
                    gap_left      <= pick_gap(tx_idle_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink ready: long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_served < hold_requests) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_served  <= holds_served + 1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            gap = pick_gap(rx_idle_pct);
            m_axis_tready <= (gap == 0);
            stall_left    <= (gap > 0) ? gap - 1 : 0;
        end
    end

    // monitor: every accepted byte against the oldest expectation
    always @(posedge i_clk) begin
        sensor_byte_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                note_failure($sformatf("unexpected byte %02h last %0b ack %0b",
                    m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== want.data)
                    note_failure($sformatf("read_byte expected %02h actual %02h",
                        want.data, m_axis_tdata));
                if (m_axis_tlast !== want.last)
                    note_failure($sformatf("last expected %0b actual %0b",
                        want.last, m_axis_tlast));
                if (m_axis_tuser !== want.ack)
                    note_failure($sformatf("acknowledged expected %0b actual %0b",
                        want.ack, m_axis_tuser));
            end
        end
    end

    task automatic queue_txn(t_mode mode, int addr, int wlen, logic [7:0] cmd,
                             logic [7:0] data, int rlen);
        t_txn txn;
        txn.mode         = mode;
        txn.address      = addr[6:0];
        txn.write_length = wlen[7:0];
        txn.command_byte = cmd;
        txn.data_byte    = data;
        txn.read_length  = rlen[6:0];
        pending_txns.push_back(txn);
    endtask

    // mostly well-formed sensor traffic, some noise and foreign addresses
    task automatic queue_random_txn();
        int         pick;
        t_mode      mode;
        int         addr;
        int         wlen;
        int         rlen;
        logic [7:0] cmd;
        pick = $urandom_range(99);
        mode = (pick < 5) ? MODE_NONE : (pick < 30) ? MODE_WRITE :
               (pick < 50) ? MODE_READ : MODE_WRITE_READ;
        addr = ($urandom_range(99) < 85) ? SENSOR_ADDR : $urandom_range(127);
        case ($urandom_range(5))
            0: cmd = CMD_MEAS_T;
            1: cmd = CMD_MEAS_RH;
            2: cmd = CMD_READ_UREG;
            3: cmd = CMD_WRITE_UREG;
            4: cmd = ($urandom_range(3) == 0) ? CMD_SOFT_RESET : CMD_MEAS_T;
            default: cmd = 8'($urandom_range(255));
        endcase
        pick = $urandom_range(99);
        wlen = (pick < 70) ? $urandom_range(2, 1) : (pick < 80) ? 0 : $urandom_range(255);
        pick = $urandom_range(99);
        rlen = (pick < 70) ? $urandom_range(3, 1) : (pick < 85) ? 0 :
               (pick < 95) ? $urandom_range(16, 4) : $urandom_range(127, 17);
        queue_txn(mode, addr, wlen, cmd, 8'($urandom_range(255)), rlen);
    endtask

    // hold the sender until the stream is empty and the pipeline settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_txns.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // register writes, only ever issued with the block idle
    task automatic set_readings(logic signed [14:0] temp, logic signed [14:0] humi);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEMPERATURE;
        i_cfg_wdata <= temp;
        @(posedge i_clk);
        i_cfg_index <= CFG_HUMIDITY;
        i_cfg_wdata <= humi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_temp = temp;
        model_humi = humi;
        settings_used++;
    endtask

    initial begin
        logic signed [14:0] temps[RAND_PHASES];
        logic signed [14:0] humis[RAND_PHASES];

        // raw register extremes, clamp limits, and just past the limits
        temps = '{-15'sd16384, TEMP_LO, TEMP_HI, 15'sd16383, -15'sd4686, 15'sd0, 15'sd0};
        humis = '{15'sd16383, HUMI_LO, HUMI_HI, -15'sd16384, 15'sd11901, 15'sd0, 15'sd0};
        temps[5] = 15'($urandom_range(17572) - 4685);
        humis[5] = 15'($urandom_range(12500) - 600);
        temps[6] = 15'($urandom_range(32767));
        humis[6] = 15'($urandom_range(32767));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed part at reset readings
        @(negedge i_clk);
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        // nothing pending reads zeros
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 2);
        queue_txn(MODE_WRITE, SENSOR_ADDR, 1, CMD_MEAS_T, 8'h00, 0);
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 2);
        // a read clears the pending command
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 2);
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_MEAS_RH, 8'h00, 2);
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_READ_UREG, 8'h00, 3);
        queue_txn(MODE_WRITE, SENSOR_ADDR, 2, CMD_WRITE_UREG, 8'hA5, 0);
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_READ_UREG, 8'h00, 1);
        // user register write with one byte only leaves it alone
        queue_txn(MODE_WRITE, SENSOR_ADDR, 1, CMD_WRITE_UREG, 8'h5A, 0);
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_READ_UREG, 8'h00, 2);
        queue_txn(MODE_WRITE, SENSOR_ADDR, 255, CMD_SOFT_RESET, 8'hFF, 0);
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_READ_UREG, 8'h00, 1);
        // short read gives the high byte only
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_MEAS_T, 8'h00, 1);
        // zero read length and the unused mode both keep the pending command
        queue_txn(MODE_WRITE, SENSOR_ADDR, 1, CMD_MEAS_RH, 8'h00, 0);
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 0);
        queue_txn(MODE_NONE, SENSOR_ADDR, 1, CMD_MEAS_T, 8'h00, 5);
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 2);
        // zero write length has no effect
        queue_txn(MODE_WRITE, SENSOR_ADDR, 0, CMD_MEAS_T, 8'h00, 0);
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 1);
        // unknown command clears a pending one
        queue_txn(MODE_WRITE, SENSOR_ADDR, 1, CMD_MEAS_T, 8'h00, 0);
        queue_txn(MODE_WRITE, SENSOR_ADDR, 1, 8'h00, 8'h00, 0);
        queue_txn(MODE_READ, SENSOR_ADDR, 0, 8'h00, 8'h00, 2);
        // foreign addresses: zeros without acknowledge, long read saturated
        queue_txn(MODE_WRITE_READ, 65, 1, CMD_MEAS_T, 8'h00, 3);
        queue_txn(MODE_WRITE_READ, 127, 255, 8'hFF, 8'hFF, 127);
        queue_txn(MODE_READ, 0, 0, 8'h00, 8'h00, 1);
        // long reads on the sensor
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_MEAS_T, 8'h00, 127);
        queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_MEAS_RH, 8'h00, 64);
        wait_drained();

        // random phases, one reading setting each, idling varied per phase
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_readings(temps[p], humis[p]);
            @(negedge i_clk);
            tx_idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 60);
            rx_idle_pct = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 30 : 60);
            queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_MEAS_T, 8'h00, 2);
            queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1, CMD_MEAS_RH, 8'h00, 2);
            for (int i = 0; i < RAND_PER_PHASE; i++) queue_random_txn();
            // sender pauses here until every byte is back
            wait_drained();

            // once: sink holds off while the sender keeps the queue full
            if (p == 2) begin
                tx_idle_pct = 0;
                hold_requests++;
                for (int i = 0; i < BURST_WORDS; i++)
                    queue_txn(MODE_WRITE_READ, SENSOR_ADDR, 1,
                              ($urandom_range(1) != 0) ? CMD_MEAS_T : CMD_MEAS_RH,
                              8'($urandom_range(255)), $urandom_range(4, 2));
                wait_drained();
            end
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_bytes.size() != 0)
            note_failure($sformatf("%0d read bytes never arrived", expected_bytes.size()));

        $display("run covered %0d transaction words and %0d read bytes over %0d settings",
            words_taken, bytes_checked, settings_used + 1);
        $display("including clamped extremes, a long sink hold-off and %0d mismatches",
            fail_count);
        if (fail_count == 0) begin
            $display("i2c_humidity_temp_sensor_model_top test passed");
        end else begin
            $display("i2c_humidity_temp_sensor_model_top test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ihts_pkg.sv
hw/rtl/ihts_front.sv
hw/rtl/ihts_code.sv
hw/rtl/ihts_queue.sv
hw/rtl/ihts_back.sv
hw/rtl/i2c_humidity_temp_sensor_model_top.sv
hw/rtl/ihts_checker.sv
bench/testbench.sv
